### rtl/core/imh_pkg.sv
// Package for the indexed min-heap: widths, opcodes and status codes.
package imh_pkg;

  localparam int CAPACITY_DEF = 1024;
  localparam int NUM_ITEMS    = 1024;
  localparam int ID_W         = 10;
  localparam int WT_W         = 31;
  localparam int CNT_OUT_W    = 11;

  localparam logic [1:0] OP_INSERT = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_APPEND = 2'd2;
  localparam logic [1:0] OP_BUILD  = 2'd3;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FULL    = 2'd1;
  localparam logic [1:0] ST_ABSENT  = 2'd2;
  localparam logic [1:0] ST_PRESENT = 2'd3;

endpackage

### rtl/core/imh_ram.sv
// Synchronous RAM, one write port and two registered read ports.
module imh_ram #(
  parameter int DW    = 10,
  parameter int DEPTH = 1024,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wa,
  input  logic [DW-1:0] wd,
  input  logic          rea,
  input  logic [AW-1:0] raa,
  output logic [DW-1:0] qa,
  input  logic          reb,
  input  logic [AW-1:0] rab,
  output logic [DW-1:0] qb
);

  logic [DW-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
  end

  // read ports, data held when not enabled
  always_ff @(posedge clk) begin
    if (rea) begin
      qa <= mem[raa];
    end
    if (reb) begin
      qb <= mem[rab];
    end
  end

endmodule

### rtl/core/indexed_min_heap.sv
// Indexed binary min-heap top level: sequencer over slot, position and weight RAMs.
//
//   channel | direction | beat fields
//   req     | in        | opcode, item_id, weight
//   rsp     | out       | min_item, min_weight, item_count, is_empty, status
//
// One operation at a time. Each sift level runs a slot read, a weight read, then a compare
// and move. A sift ends with up to one more check and a write-back. Insert: a position
// lookup, the climb, then a read of the top. Remove adds a fetch of the last slot and a
// reload of the vacated slot between down and up. Build: a position sweep over every slot,
// then per slot, from the last up to the top, a load and a sift down. After reset every
// entry of the position RAM is cleared with req_stall high. A result waits in the output
// register while rsp_stall is high.
module indexed_min_heap import imh_pkg::*; #(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 req_valid,
  output logic                 req_stall,
  input  logic [1:0]           opcode,
  input  logic [ID_W-1:0]      item_id,
  input  logic [WT_W-1:0]      weight,
  output logic                 rsp_valid,
  input  logic                 rsp_stall,
  output logic [ID_W-1:0]      min_item,
  output logic [WT_W-1:0]      min_weight,
  output logic [CNT_OUT_W-1:0] item_count,
  output logic                 is_empty,
  output logic [1:0]           status
);

  localparam int SW = $clog2(CAPACITY + 1);

  localparam logic [4:0] S_CLR  = 5'd0;
  localparam logic [4:0] S_IDLE = 5'd1;
  localparam logic [4:0] S_CHK  = 5'd2;
  localparam logic [4:0] S_RCHK = 5'd3;
  localparam logic [4:0] S_RM1  = 5'd4;
  localparam logic [4:0] S_RM2  = 5'd5;
  localparam logic [4:0] S_UP   = 5'd6;
  localparam logic [4:0] S_UP1  = 5'd7;
  localparam logic [4:0] S_UP2  = 5'd8;
  localparam logic [4:0] S_UPW  = 5'd9;
  localparam logic [4:0] S_DN   = 5'd10;
  localparam logic [4:0] S_DN1  = 5'd11;
  localparam logic [4:0] S_DN2  = 5'd12;
  localparam logic [4:0] S_DNW  = 5'd13;
  localparam logic [4:0] S_LD   = 5'd14;
  localparam logic [4:0] S_LD1  = 5'd15;
  localparam logic [4:0] S_LD2  = 5'd16;
  localparam logic [4:0] S_BM0  = 5'd17;
  localparam logic [4:0] S_BM1  = 5'd18;
  localparam logic [4:0] S_FIN  = 5'd19;
  localparam logic [4:0] S_F1   = 5'd20;
  localparam logic [4:0] S_F2   = 5'd21;

  logic [4:0]      state, state_next;
  logic [1:0]      op, op_next;
  logic [ID_W-1:0] id, id_next;
  logic [WT_W-1:0] w, w_next;
  logic [SW-1:0]   cnt, cnt_next;
  logic [SW-1:0]   pos, pos_next;
  logic [SW-1:0]   s0, s0_next;
  logic [SW-1:0]   bi, bi_next;
  logic [ID_W-1:0] mid, mid_next;
  logic [WT_W-1:0] mw, mw_next;
  logic [1:0]      st, st_next;
  logic [ID_W-1:0] clr, clr_next;

  // memory ports
  logic            hs_we, hs_rea, hs_reb;
  logic [SW-1:0]   hs_wa, hs_raa, hs_rab;
  logic [ID_W-1:0] hs_wd, hs_qa, hs_qb;
  logic            so_we, so_re;
  logic [ID_W-1:0] so_wa, so_ra;
  logic [SW-1:0]   so_wd, so_q;
  logic            wt_we, wt_rea, wt_reb;
  logic [ID_W-1:0] wt_wa, wt_raa, wt_rab;
  logic [WT_W-1:0] wt_wd, wt_qa, wt_qb;

  logic            load_rsp;
  logic [SW:0]     c, c1;
  logic            c1_ok, dn_go, pick_b;
  logic [ID_W-1:0] ch_id;
  logic [WT_W-1:0] ch_w;
  logic [SW-1:0]   ch_pos;

  imh_ram #(.DW(ID_W), .DEPTH(CAPACITY + 1), .AW(SW)) u_slots (
    .clk(clk), .we(hs_we), .wa(hs_wa), .wd(hs_wd),
    .rea(hs_rea), .raa(hs_raa), .qa(hs_qa),
    .reb(hs_reb), .rab(hs_rab), .qb(hs_qb)
  );

  imh_ram #(.DW(SW), .DEPTH(NUM_ITEMS), .AW(ID_W)) u_pos (
    .clk(clk), .we(so_we), .wa(so_wa), .wd(so_wd),
    .rea(so_re), .raa(so_ra), .qa(so_q),
    .reb(1'b0), .rab(so_ra), .qb()
  );

  imh_ram #(.DW(WT_W), .DEPTH(NUM_ITEMS), .AW(ID_W)) u_wt (
    .clk(clk), .we(wt_we), .wa(wt_wa), .wd(wt_wd),
    .rea(wt_rea), .raa(wt_raa), .qa(wt_qa),
    .reb(wt_reb), .rab(wt_rab), .qb(wt_qb)
  );

  // child geometry for sift down
  assign c      = {pos, 1'b0};
  assign c1     = c + (SW + 1)'(1);
  assign c1_ok  = c1 <= {1'b0, cnt};
  assign dn_go  = pos <= (cnt >> 1);
  assign pick_b = c1_ok && (wt_qb < wt_qa);
  assign ch_id  = pick_b ? hs_qb : hs_qa;
  assign ch_w   = pick_b ? wt_qb : wt_qa;
  assign ch_pos = pick_b ? c1[SW-1:0] : c[SW-1:0];

  assign req_stall = (state != S_IDLE);
  assign load_rsp  = (state == S_F2) && !(rsp_valid && rsp_stall);

  // sequencer
  always_comb begin
    state_next = state;
    op_next  = op;
    id_next  = id;
    w_next   = w;
    cnt_next = cnt;
    pos_next = pos;
    s0_next  = s0;
    bi_next  = bi;
    mid_next = mid;
    mw_next  = mw;
    st_next  = st;
    clr_next = clr;
    hs_we = 1'b0; hs_wa = pos; hs_wd = mid;
    hs_rea = 1'b0; hs_raa = pos; hs_reb = 1'b0; hs_rab = pos;
    so_we = 1'b0; so_wa = mid; so_wd = pos;
    so_re = 1'b0; so_ra = id;
    wt_we = 1'b0; wt_wa = id; wt_wd = w;
    wt_rea = 1'b0; wt_raa = hs_qa; wt_reb = 1'b0; wt_rab = hs_qb;
    unique case (state)
      S_CLR: begin
        so_we = 1'b1; so_wa = clr; so_wd = '0;
        clr_next = clr + ID_W'(1);
        if (clr == {ID_W{1'b1}}) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (req_valid) begin
          op_next = opcode;
          id_next = item_id;
          w_next  = weight;
          st_next = ST_OK;
          unique case (opcode)
            OP_INSERT, OP_APPEND: begin
              if (cnt == SW'(CAPACITY)) begin
                st_next = ST_FULL;
                state_next = S_FIN;
              end else begin
                so_re = 1'b1; so_ra = item_id;
                state_next = S_CHK;
              end
            end
            OP_REMOVE: begin
              so_re = 1'b1; so_ra = item_id;
              state_next = S_RCHK;
            end
            default: begin
              bi_next = SW'(1);
              state_next = (cnt == '0) ? S_FIN : S_BM0;
            end
          endcase
        end
      end
      S_CHK: begin
        if (so_q != '0) begin
          st_next = ST_PRESENT;
          state_next = S_FIN;
        end else begin
          wt_we = 1'b1;
          cnt_next = cnt + SW'(1);
          mid_next = id;
          mw_next  = w;
          pos_next = cnt + SW'(1);
          if (op == OP_APPEND) begin
            hs_we = 1'b1; hs_wa = cnt + SW'(1); hs_wd = id;
            so_we = 1'b1; so_wa = id; so_wd = cnt + SW'(1);
            state_next = S_FIN;
          end else begin
            state_next = S_UP;
          end
        end
      end
      S_RCHK: begin
        if (so_q == '0 || so_q > cnt) begin
          st_next = ST_ABSENT;
          state_next = S_FIN;
        end else begin
          so_we = 1'b1; so_wa = id; so_wd = '0;
          cnt_next = cnt - SW'(1);
          if (so_q == cnt) begin
            state_next = S_FIN;
          end else begin
            hs_rea = 1'b1; hs_raa = cnt;
            pos_next = so_q;
            s0_next  = so_q;
            state_next = S_RM1;
          end
        end
      end
      S_RM1: begin
        wt_rea = 1'b1;
        state_next = S_RM2;
      end
      S_RM2: begin
        mid_next = hs_qa;
        mw_next  = wt_qa;
        state_next = S_DN;
      end
      // sift up: hole walks toward the top
      S_UP: begin
        if (pos == SW'(1)) begin
          state_next = S_UPW;
        end else begin
          hs_rea = 1'b1; hs_raa = pos >> 1;
          state_next = S_UP1;
        end
      end
      S_UP1: begin
        wt_rea = 1'b1;
        state_next = S_UP2;
      end
      S_UP2: begin
        if (mw < wt_qa) begin
          hs_we = 1'b1; hs_wa = pos; hs_wd = hs_qa;
          so_we = 1'b1; so_wa = hs_qa; so_wd = pos;
          pos_next = pos >> 1;
          state_next = S_UP;
        end else begin
          state_next = S_UPW;
        end
      end
      S_UPW: begin
        hs_we = 1'b1; so_we = 1'b1;
        state_next = S_FIN;
      end
      // sift down: hole walks toward the lighter child
      S_DN: begin
        if (dn_go) begin
          hs_rea = 1'b1; hs_raa = c[SW-1:0];
          hs_reb = 1'b1; hs_rab = c1_ok ? c1[SW-1:0] : c[SW-1:0];
          state_next = S_DN1;
        end else begin
          state_next = S_DNW;
        end
      end
      S_DN1: begin
        wt_rea = 1'b1; wt_reb = 1'b1;
        state_next = S_DN2;
      end
      S_DN2: begin
        if (ch_w < mw) begin
          hs_we = 1'b1; hs_wa = pos; hs_wd = ch_id;
          so_we = 1'b1; so_wa = ch_id; so_wd = pos;
          pos_next = ch_pos;
          state_next = S_DN;
        end else begin
          state_next = S_DNW;
        end
      end
      S_DNW: begin
        hs_we = 1'b1; so_we = 1'b1;
        if (op == OP_REMOVE) begin
          pos_next = s0;
          state_next = S_LD;
        end else if (bi == SW'(1)) begin
          state_next = S_FIN;
        end else begin
          bi_next  = bi - SW'(1);
          pos_next = bi - SW'(1);
          state_next = S_LD;
        end
      end
      // load the item at pos as the moving item
      S_LD: begin
        hs_rea = 1'b1; hs_raa = pos;
        state_next = S_LD1;
      end
      S_LD1: begin
        wt_rea = 1'b1;
        state_next = S_LD2;
      end
      S_LD2: begin
        mid_next = hs_qa;
        mw_next  = wt_qa;
        state_next = (op == OP_REMOVE) ? S_UP : S_DN;
      end
      // build: refresh the position map, then heapify from the last slot
      S_BM0: begin
        hs_rea = 1'b1; hs_raa = bi;
        state_next = S_BM1;
      end
      S_BM1: begin
        so_we = 1'b1; so_wa = hs_qa; so_wd = bi;
        if (bi == cnt) begin
          pos_next = cnt;
          state_next = S_LD;
        end else begin
          bi_next = bi + SW'(1);
          state_next = S_BM0;
        end
      end
      // read the top for the result
      S_FIN: begin
        hs_rea = 1'b1; hs_raa = SW'(1);
        state_next = S_F1;
      end
      S_F1: begin
        wt_rea = 1'b1;
        state_next = S_F2;
      end
      S_F2: begin
        if (load_rsp) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLR;
      cnt   <= '0;
      clr   <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      clr   <= clr_next;
      if (load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // working and result payload
  always_ff @(posedge clk) begin
    op  <= op_next;
    id  <= id_next;
    w   <= w_next;
    pos <= pos_next;
    s0  <= s0_next;
    bi  <= bi_next;
    mid <= mid_next;
    mw  <= mw_next;
    st  <= st_next;
    if (load_rsp) begin
      is_empty   <= (cnt == '0);
      min_item   <= (cnt == '0) ? '0 : hs_qa;
      min_weight <= (cnt == '0) ? '0 : wt_qa;
      item_count <= CNT_OUT_W'(cnt);
      status     <= st;
    end
  end

endmodule

### rtl/core/imh_chk.sv
// Port-level checker for the indexed min-heap, bound to the top level.
module imh_chk import imh_pkg::*; (
  input logic                 clk,
  input logic                 rst,
  input logic                 rsp_valid,
  input logic                 rsp_stall,
  input logic [ID_W-1:0]      min_item,
  input logic [WT_W-1:0]      min_weight,
  input logic [CNT_OUT_W-1:0] item_count,
  input logic                 is_empty
);

  // empty heap reports a zero top
  a_empty_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && is_empty |-> min_item == '0 && min_weight == '0)
    else $error("empty result with nonzero top");

  // empty flag agrees with the count
  a_empty_cnt: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> is_empty == (item_count == '0))
    else $error("empty flag and count disagree");

  // a stalled beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_stall |=> rsp_valid && $stable(min_item) && $stable(item_count))
    else $error("stalled result changed");

endmodule

bind indexed_min_heap imh_chk u_imh_chk (
  .clk(clk), .rst(rst), .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
  .min_item(min_item), .min_weight(min_weight), .item_count(item_count),
  .is_empty(is_empty)
);

### sim/indexed_min_heap_test.sv
// Testbench for indexed_min_heap: queued stimulus, in-line heap predictor, result checker.
`timescale 1ns / 100ps

module indexed_min_heap_test;
  import imh_pkg::*;

  localparam int HEAP_CAP = CAPACITY_DEF;
  localparam int MAX_CYCLES = 3000000;
  localparam int IDLE_PCT = 8;

  typedef struct packed {
    logic [1:0]      op;
    logic [ID_W-1:0] id;
    logic [WT_W-1:0] w;
    logic            drain;
  } heap_op_t;

  typedef struct packed {
    logic [ID_W-1:0]      item;
    logic [WT_W-1:0]      wt;
    logic [CNT_OUT_W-1:0] cnt;
    logic                 empty;
    logic [1:0]           st;
  } heap_view_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  logic [1:0] opcode = OP_BUILD;
  logic [ID_W-1:0] item_id = '0;
  logic [WT_W-1:0] weight = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  logic [ID_W-1:0] min_item;
  logic [WT_W-1:0] min_weight;
  logic [CNT_OUT_W-1:0] item_count;
  logic is_empty;
  logic [1:0] status;

  heap_op_t   pending_ops[$];
  heap_view_t expected_views[$];
  int cycle_cnt = 0;
  int mismatches = 0;
  int beats_in = 0;
  int beats_out = 0;
  int full_seen = 0;
  int absent_seen = 0;
  int dup_seen = 0;

  // model heap state
  logic [ID_W-1:0] slot_item[1:HEAP_CAP];
  int              item_slot[0:NUM_ITEMS-1];
  logic [WT_W-1:0] item_wt[0:NUM_ITEMS-1];
  int              held;

  // stimulus-side presence tracking
  logic [ID_W-1:0] live_ids[$];
  bit              live[0:NUM_ITEMS-1];

  indexed_min_heap DUT (
    .clk(clk), .rst(rst),
    .req_valid(req_valid), .req_stall(req_stall),
    .opcode(opcode), .item_id(item_id), .weight(weight),
    .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
    .min_item(min_item), .min_weight(min_weight), .item_count(item_count),
    .is_empty(is_empty), .status(status)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [WT_W-1:0] slot_wt(int s);
    return item_wt[slot_item[s]];
  endfunction

  function automatic void swap_slot(int s, int t);
    logic [ID_W-1:0] tmp;
    tmp = slot_item[s];
    slot_item[s] = slot_item[t];
    slot_item[t] = tmp;
    item_slot[slot_item[s]] = s;
    item_slot[slot_item[t]] = t;
  endfunction

  function automatic void sink(int s);
    int c;
    while (s <= held / 2) begin
      c = 2 * s;
      if (c + 1 <= held && slot_wt(c + 1) < slot_wt(c)) c = c + 1;
      if (slot_wt(c) < slot_wt(s)) begin
        swap_slot(c, s);
        s = c;
      end else break;
    end
  endfunction

  function automatic void rise(int s);
    while (s > 1 && slot_wt(s) < slot_wt(s / 2)) begin
      swap_slot(s, s / 2);
      s = s / 2;
    end
  endfunction

  // apply one operation to the model heap and return the expected view
  function automatic heap_view_t heap_apply(logic [1:0] op, logic [ID_W-1:0] id,
                                            logic [WT_W-1:0] w);
    heap_view_t v;
    int s;
    v.st = ST_OK;
    case (op)
      OP_INSERT, OP_APPEND: begin
        if (held >= HEAP_CAP) v.st = ST_FULL;
        else if (item_slot[id] != 0) v.st = ST_PRESENT;
        else begin
          item_wt[id] = w;
          held++;
          slot_item[held] = id;
          item_slot[id] = held;
          if (op == OP_INSERT) rise(held);
        end
      end
      OP_REMOVE: begin
        s = item_slot[id];
        if (s == 0 || s > held) v.st = ST_ABSENT;
        else begin
          item_slot[id] = 0;
          if (s == held) held--;
          else begin
            slot_item[s] = slot_item[held];
            held--;
            item_slot[slot_item[s]] = s;
            sink(s);
            rise(s);
          end
        end
      end
      default: begin
        for (int i = 1; i <= held; i++) item_slot[slot_item[i]] = i;
        for (int i = held; i > 0; i--) sink(i);
      end
    endcase
    if (held == 0) begin
      v.item = '0;
      v.wt = '0;
      v.empty = 1'b1;
    end else begin
      v.item = slot_item[1];
      v.wt = slot_wt(1);
      v.empty = 1'b0;
    end
    v.cnt = held[CNT_OUT_W-1:0];
    return v;
  endfunction

  // quiet window: no idling on either side
  function automatic bit take_idle();
    if (cycle_cnt > 30000 && cycle_cnt < 60000) return 1'b0;
    return $urandom_range(99) < IDLE_PCT;
  endfunction

  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt > MAX_CYCLES) begin
      $display("timeout after %0d cycles, %0d results pending", cycle_cnt,
               expected_views.size());
      $display("FAILURE");
      $finish;
    end
  end

  // request driver: predict on acceptance, then present the next beat
  always @(posedge clk) begin
    heap_op_t nxt;
    if (!rst) begin
      if (req_valid && !req_stall) begin
        expected_views = {expected_views, heap_apply(opcode, item_id, weight)};
        beats_in++;
      end
      if (!req_valid || !req_stall) begin
        if (pending_ops.size() > 0 && !take_idle() &&
            !(pending_ops[0].drain && expected_views.size() > 0)) begin
          nxt = pending_ops.pop_front();
          req_valid <= 1'b1;
          opcode <= nxt.op;
          item_id <= nxt.id;
          weight <= nxt.w;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // response side: random backpressure and field checks
  always @(posedge clk) begin
    heap_view_t e;
    if (!rst) begin
      if (rsp_valid && !rsp_stall) begin
        beats_out++;
        if (expected_views.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result beat, item %0d", min_item);
        end else begin
          e = expected_views.pop_front();
          if (e.st == ST_FULL) full_seen++;
          if (e.st == ST_ABSENT) absent_seen++;
          if (e.st == ST_PRESENT) dup_seen++;
          if (min_item !== e.item || min_weight !== e.wt || item_count !== e.cnt ||
              is_empty !== e.empty || status !== e.st) begin
            mismatches++;
            if (mismatches <= 10)
              $display({"beat %0d: exp item %0d wt %0d cnt %0d empty %0b st %0d, ",
                        "got %0d %0d %0d %0b %0d"},
                       beats_out, e.item, e.wt, e.cnt, e.empty, e.st,
                       min_item, min_weight, item_count, is_empty, status);
          end
        end
      end
      rsp_stall <= take_idle();
    end
  end

  task automatic queue_op(logic [1:0] op, int id, logic [WT_W-1:0] w, bit drain = 1'b0);
    heap_op_t t;
    int idx;
    t.op = op;
    t.id = id[ID_W-1:0];
    t.w = w;
    t.drain = drain;
    pending_ops = {pending_ops, t};
    // keep the stimulus-side presence list in step
    if ((op == OP_INSERT || op == OP_APPEND) && live_ids.size() < HEAP_CAP && !live[id]) begin
      live[id] = 1'b1;
      live_ids = {live_ids, id[ID_W-1:0]};
    end else if (op == OP_REMOVE && live[id]) begin
      live[id] = 1'b0;
      idx = -1;
      foreach (live_ids[i]) if (live_ids[i] == id) idx = i;
      live_ids.delete(idx);
    end
  endtask

  function automatic logic [WT_W-1:0] rand_wt();
    case ($urandom_range(3))
      0: return WT_W'($urandom_range(7));
      1: return WT_W'($urandom_range(1000));
      default: return WT_W'($urandom());
    endcase
  endfunction

  function automatic int some_live();
    return int'(live_ids[$urandom_range(live_ids.size() - 1)]);
  endfunction

  // random mix of insert / remove / append / build
  task automatic random_ops(int n, int id_span);
    int r;
    for (int k = 0; k < n; k++) begin
      r = $urandom_range(99);
      if (r < 45) queue_op(OP_INSERT, $urandom_range(id_span), rand_wt());
      else if (r < 80 && live_ids.size() > 0) queue_op(OP_REMOVE, some_live(), rand_wt());
      else if (r < 85) queue_op(OP_REMOVE, $urandom_range(NUM_ITEMS - 1), rand_wt());
      else if (r < 95) queue_op(OP_APPEND, $urandom_range(id_span), rand_wt());
      else queue_op(OP_BUILD, $urandom_range(NUM_ITEMS - 1), rand_wt());
    end
  endtask

  initial begin
    int f;
    held = 0;
    for (int i = 0; i < NUM_ITEMS; i++) begin
      item_slot[i] = 0;
      live[i] = 1'b0;
    end

    // directed: empty heap, extremes, duplicates, ties, removal cases
    queue_op(OP_BUILD, 1023, 31'h7FFF_FFFF);
    queue_op(OP_REMOVE, 5, 0);
    queue_op(OP_INSERT, 1023, 31'h7FFF_FFFF);
    queue_op(OP_INSERT, 0, 0);
    queue_op(OP_INSERT, 0, 77);
    queue_op(OP_INSERT, 512, 0);
    queue_op(OP_INSERT, 341, 31'h2AAA_AAAA);
    queue_op(OP_APPEND, 682, 31'h5555_5555);
    queue_op(OP_APPEND, 1, 0);
    queue_op(OP_APPEND, 341, 3);
    queue_op(OP_INSERT, 7, 31'h2AAA_AAAA);
    queue_op(OP_BUILD, 0, 0);
    queue_op(OP_REMOVE, 0, 0);
    queue_op(OP_REMOVE, 7, 0);
    queue_op(OP_REMOVE, 682, 0);
    queue_op(OP_REMOVE, 682, 0);
    queue_op(OP_REMOVE, 1023, 0);
    queue_op(OP_REMOVE, 512, 0);
    queue_op(OP_REMOVE, 1, 0);
    queue_op(OP_REMOVE, 341, 0);
    queue_op(OP_INSERT, 9, 4, 1'b1);

    // small ids with many duplicates and absent removes, then the full id range
    random_ops(120, 31);
    random_ops(80, NUM_ITEMS - 1);

    // fill to capacity with every absent id, probe the full case, rebuild, remove 40 and rebuild
    f = 0;
    for (int i = 0; i < NUM_ITEMS; i++) begin
      if (live_ids.size() < HEAP_CAP && !live[i]) begin
        queue_op(($urandom_range(1)) ? OP_APPEND : OP_INSERT, i, rand_wt(), f == 0);
        f++;
      end
    end
    queue_op(OP_INSERT, some_live(), 0);
    queue_op(OP_INSERT, 100, 0);
    queue_op(OP_APPEND, 200, 1);
    queue_op(OP_BUILD, 0, 0);
    for (int k = 0; k < 40; k++) queue_op(OP_REMOVE, some_live(), 0);
    queue_op(OP_BUILD, 0, 0);

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    wait (pending_ops.size() == 0 && expected_views.size() == 0);
    @(posedge clk);
    wait (!req_valid && expected_views.size() == 0);
    repeat (200) @(posedge clk);

    $display("ran %0d ops, %0d results; status full %0d, absent %0d, duplicate %0d",
             beats_in, beats_out, full_seen, absent_seen, dup_seen);
    $display("heap filled to capacity, rebuilt and partly drained; %0d mismatches",
             mismatches);
    if (mismatches == 0 && expected_views.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/core/imh_pkg.sv
rtl/core/imh_ram.sv
rtl/core/indexed_min_heap.sv
rtl/core/imh_chk.sv
sim/indexed_min_heap_test.sv
